FILE: hw/rtl/cppg_pkg.sv
`default_nettype none

package cppg_pkg;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_SUM,
      ST_SQRT,
      ST_ROUND,
      ST_RADIUS,
      ST_RSQ,
      ST_COUNT,
      ST_MUL_I,
      ST_DIFF_I,
      ST_POINT,
      ST_DONE
   } state_type;

   // What the shared square root is currently working for
   typedef enum logic [1:0] {
      PH_RADIUS,
      PH_COUNT,
      PH_POINT
   } phase_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_POINT     = 2'd0,
      STATUS_STARTED   = 2'd1,
      STATUS_TOO_SMALL = 2'd2,
      STATUS_NO_CIRCLE = 2'd3
   } status_type;

   // Request modes
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_NEXT  = 1'b1;

endpackage

`default_nettype wire

FILE: hw/rtl/cppg_req_if.sv
`default_nettype none

interface cppg_req_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic signed [COORD_BITS-1:0] center_x;
   logic signed [COORD_BITS-1:0] center_y;
   logic signed [COORD_BITS-1:0] edge_x;
   logic signed [COORD_BITS-1:0] edge_y;

   modport source (
      output valid, mode, center_x, center_y, edge_x, edge_y,
      input  ready
   );

   modport sink (
      input  valid, mode, center_x, center_y, edge_x, edge_y,
      output ready
   );
endinterface

`default_nettype wire

FILE: hw/rtl/cppg_rsp_if.sv
`default_nettype none

interface cppg_rsp_if #(
   parameter int COORD_BITS = 16
);
   logic                           valid;
   logic                           ready;
   cppg_pkg::status_type           status;
   logic signed [COORD_BITS+1:0]   point_x;
   logic signed [COORD_BITS+1:0]   point_y;
   logic                           last_point;

   modport source (
      output valid, status, point_x, point_y, last_point,
      input  ready
   );

   modport sink (
      input  valid, status, point_x, point_y, last_point,
      output ready
   );
endinterface

`default_nettype wire

FILE: hw/rtl/circle_perimeter_point_generator_unit.sv
// A point beat runs one square root through the shared square root unit, which
// retires one root bit per cycle, and a start beat runs up to two; a new request is
// accepted only once the last result has been loaded into the output register.
// Reset (synchronous, active high) clears the sequencer, the circle state and the
// output valid; no circle is active afterwards.
`default_nettype none

module circle_perimeter_point_generator_unit #(
   parameter int COORD_BITS = 16
) (
   input wire          clock,
   input wire          reset,
   cppg_req_if.sink    req_if,
   cppg_rsp_if.source  rsp_if
);

   localparam int CB    = COORD_BITS;
   localparam int OW    = CB + 2;        // output coordinate width
   localparam int RW    = CB + 1;        // root, index and count width
   localparam int SW    = 2 * CB + 2;    // squared value width
   localparam int MW    = CB + 2;        // signed multiplier operand width
   localparam int REMW  = CB + 2;        // square root remainder width
   localparam int STEPS = CB + 1;        // root bits, one per cycle
   localparam int CNTW  = $clog2(STEPS);

   // Sequencer and circle state
   cppg_pkg::state_type state_ff, state_in;
   cppg_pkg::phase_type phase_ff, phase_in;
   logic                active_ff, active_in;
   logic [2:0]          octant_ff, octant_in;
   logic [RW-1:0]       step_ff, step_in;
   logic [RW-1:0]       points_ff, points_in;
   logic [SW-1:0]       rsq_ff, rsq_in;
   logic signed [CB-1:0] ctr_x_ff, ctr_x_in;
   logic signed [CB-1:0] ctr_y_ff, ctr_y_in;

   // Working registers
   logic signed [CB:0]  dx_ff, dx_in;
   logic signed [CB:0]  dy_ff, dy_in;
   logic [RW-1:0]       idx_ff, idx_in;
   logic [SW-1:0]       acc_ff, acc_in;
   logic [SW-1:0]       prod_ff, prod_in;
   logic [RW-1:0]       rnd_ff, rnd_in;

   // Square root unit
   logic [SW-1:0]       rad_ff, rad_in;
   logic [RW-1:0]       root_ff, root_in;
   logic [REMW-1:0]     rem_ff, rem_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;

   // Pending result and output register
   cppg_pkg::status_type res_status_ff, res_status_in;
   logic signed [OW-1:0] res_x_ff, res_x_in;
   logic signed [OW-1:0] res_y_ff, res_y_in;
   logic                 res_last_ff, res_last_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   cppg_pkg::status_type rsp_status_ff, rsp_status_in;
   logic signed [OW-1:0] rsp_x_ff, rsp_x_in;
   logic signed [OW-1:0] rsp_y_ff, rsp_y_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Combinational helpers
   logic                 req_beat;
   logic                 out_free;
   logic signed [MW-1:0] mul_op;
   logic signed [2*MW-1:0] mul_full;
   logic [REMW+1:0]      sq_cur;
   logic [REMW+1:0]      sq_trial;
   logic [REMW+1:0]      sq_diff;
   logic                 sq_fit;
   logic signed [OW-1:0] off_a;
   logic signed [OW-1:0] off_b;
   logic signed [OW-1:0] off_x;
   logic signed [OW-1:0] off_y;
   logic [RW-1:0]        step_next;

   assign req_if.ready = (state_ff == cppg_pkg::ST_IDLE);
   assign req_beat     = req_if.valid && (state_ff == cppg_pkg::ST_IDLE);
   // The output slot is free when empty or being drained this cycle.
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.point_x    = rsp_x_ff;
   assign rsp_if.point_y    = rsp_y_ff;
   assign rsp_if.last_point = rsp_last_ff;

   // Shared squaring multiplier: every square the block needs passes through here.
   always_comb begin
      case (state_ff)
         cppg_pkg::ST_MUL_X:  mul_op = MW'(dx_ff);
         cppg_pkg::ST_MUL_Y:  mul_op = MW'(dy_ff);
         cppg_pkg::ST_RADIUS: mul_op = {1'b0, rnd_ff};
         default:             mul_op = {1'b0, idx_ff};
      endcase
   end

   assign mul_full = mul_op * mul_op;
   assign prod_in  = mul_full[SW-1:0];

   // One step of the digit-by-digit square root: bring down the next bit pair,
   // try subtracting 4*root+1.
   assign sq_cur   = {rem_ff, rad_ff[SW-1 -: 2]};
   assign sq_trial = (REMW+2)'({root_ff, 2'b01});
   assign sq_fit   = (sq_cur >= sq_trial);
   assign sq_diff  = sq_cur - sq_trial;

   // Eight-way symmetry: offset (a, b) with a the rounded root and b the index.
   assign off_a = OW'({1'b0, rnd_ff});
   assign off_b = OW'({1'b0, idx_ff});

   always_comb begin
      case (octant_ff)
         3'd0:    begin off_x =  off_a; off_y =  off_b; end
         3'd1:    begin off_x =  off_b; off_y =  off_a; end
         3'd2:    begin off_x = -off_b; off_y =  off_a; end
         3'd3:    begin off_x = -off_a; off_y =  off_b; end
         3'd4:    begin off_x = -off_a; off_y = -off_b; end
         3'd5:    begin off_x = -off_b; off_y = -off_a; end
         3'd6:    begin off_x =  off_b; off_y = -off_a; end
         default: begin off_x =  off_a; off_y = -off_b; end
      endcase
   end

   assign step_next = RW'(step_ff + 1'b1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cppg_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               if (req_if.mode == cppg_pkg::MODE_START) begin
                  state_in = cppg_pkg::ST_MUL_X;
               end else if (active_ff) begin
                  state_in = cppg_pkg::ST_MUL_I;
               end else begin
                  state_in = cppg_pkg::ST_DONE;
               end
            end
         end
         cppg_pkg::ST_MUL_X:  state_in = cppg_pkg::ST_MUL_Y;
         cppg_pkg::ST_MUL_Y:  state_in = cppg_pkg::ST_SUM;
         cppg_pkg::ST_SUM:    state_in = cppg_pkg::ST_SQRT;
         cppg_pkg::ST_SQRT: begin
            if (cnt_ff == CNTW'(STEPS - 1)) begin
               state_in = cppg_pkg::ST_ROUND;
            end
         end
         cppg_pkg::ST_ROUND: begin
            unique case (phase_ff)
               cppg_pkg::PH_RADIUS: state_in = cppg_pkg::ST_RADIUS;
               cppg_pkg::PH_COUNT:  state_in = cppg_pkg::ST_COUNT;
               default:             state_in = cppg_pkg::ST_POINT;
            endcase
         end
         cppg_pkg::ST_RADIUS: begin
            if (rnd_ff == '0) begin
               state_in = cppg_pkg::ST_DONE;
            end else begin
               state_in = cppg_pkg::ST_RSQ;
            end
         end
         cppg_pkg::ST_RSQ:    state_in = cppg_pkg::ST_SQRT;
         cppg_pkg::ST_COUNT:  state_in = cppg_pkg::ST_DONE;
         cppg_pkg::ST_MUL_I:  state_in = cppg_pkg::ST_DIFF_I;
         cppg_pkg::ST_DIFF_I: state_in = cppg_pkg::ST_SQRT;
         cppg_pkg::ST_POINT:  state_in = cppg_pkg::ST_DONE;
         cppg_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = cppg_pkg::ST_IDLE;
            end
         end
         default: state_in = cppg_pkg::ST_IDLE;
      endcase
   end

   // Datapath and circle state updates
   always_comb begin
      phase_in      = phase_ff;
      active_in     = active_ff;
      octant_in     = octant_ff;
      step_in       = step_ff;
      points_in     = points_ff;
      rsq_in        = rsq_ff;
      ctr_x_in      = ctr_x_ff;
      ctr_y_in      = ctr_y_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      rnd_in        = rnd_ff;
      rad_in        = rad_ff;
      root_in       = root_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_last_in   = res_last_ff;

      unique case (state_ff)
         cppg_pkg::ST_IDLE: begin
            if (req_beat) begin
               if (req_if.mode == cppg_pkg::MODE_START) begin
                  // Abandon any running circle and capture the new geometry.
                  active_in = 1'b0;
                  octant_in = '0;
                  step_in   = '0;
                  phase_in  = cppg_pkg::PH_RADIUS;
                  ctr_x_in  = req_if.center_x;
                  ctr_y_in  = req_if.center_y;
                  dx_in     = (CB+1)'(req_if.center_x) - (CB+1)'(req_if.edge_x);
                  dy_in     = (CB+1)'(req_if.center_y) - (CB+1)'(req_if.edge_y);
               end else if (active_ff) begin
                  // Odd octants walk the index downward.
                  phase_in = cppg_pkg::PH_POINT;
                  if (octant_ff[0]) begin
                     idx_in = RW'(points_ff - step_ff - 1'b1);
                  end else begin
                     idx_in = step_ff;
                  end
               end else begin
                  res_status_in = cppg_pkg::STATUS_NO_CIRCLE;
                  res_x_in      = '0;
                  res_y_in      = '0;
                  res_last_in   = 1'b0;
               end
            end
         end
         cppg_pkg::ST_MUL_Y: begin
            acc_in = prod_ff;
         end
         cppg_pkg::ST_SUM: begin
            rad_in  = acc_ff + prod_ff;
            root_in = '0;
            rem_in  = '0;
            cnt_in  = '0;
         end
         cppg_pkg::ST_SQRT: begin
            rad_in  = {rad_ff[SW-3:0], 2'b00};
            root_in = {root_ff[RW-2:0], sq_fit};
            rem_in  = sq_fit ? sq_diff[REMW-1:0] : sq_cur[REMW-1:0];
            cnt_in  = CNTW'(cnt_ff + 1'b1);
         end
         cppg_pkg::ST_ROUND: begin
            // Round half up: step once more when the remainder exceeds the root.
            rnd_in = RW'(root_ff + RW'(rem_ff > {1'b0, root_ff}));
         end
         cppg_pkg::ST_RADIUS: begin
            if (rnd_ff == '0) begin
               res_status_in = cppg_pkg::STATUS_TOO_SMALL;
               res_x_in      = '0;
               res_y_in      = '0;
               res_last_in   = 1'b0;
            end
         end
         cppg_pkg::ST_RSQ: begin
            // Points per octant come from floor(sqrt(r*r / 2)) + 1.
            rsq_in   = prod_ff;
            rad_in   = {1'b0, prod_ff[SW-1:1]};
            root_in  = '0;
            rem_in   = '0;
            cnt_in   = '0;
            phase_in = cppg_pkg::PH_COUNT;
         end
         cppg_pkg::ST_COUNT: begin
            points_in     = RW'(root_ff + 1'b1);
            active_in     = 1'b1;
            octant_in     = '0;
            step_in       = '0;
            res_status_in = cppg_pkg::STATUS_STARTED;
            res_x_in      = '0;
            res_y_in      = '0;
            res_last_in   = 1'b0;
         end
         cppg_pkg::ST_DIFF_I: begin
            rad_in  = rsq_ff - prod_ff;
            root_in = '0;
            rem_in  = '0;
            cnt_in  = '0;
         end
         cppg_pkg::ST_POINT: begin
            res_status_in = cppg_pkg::STATUS_POINT;
            res_x_in      = OW'(ctr_x_ff) + off_x;
            res_y_in      = OW'(ctr_y_ff) + off_y;
            res_last_in   = 1'b0;
            if (step_next >= points_ff) begin
               step_in = '0;
               if (octant_ff == 3'd7) begin
                  res_last_in = 1'b1;
                  active_in   = 1'b0;
                  octant_in   = '0;
               end else begin
                  octant_in = octant_ff + 3'd1;
               end
            end else begin
               step_in = step_next;
            end
         end
         default: begin
         end
      endcase
   end

   // Output register: load the pending result once the slot frees up.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == cppg_pkg::ST_DONE) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_x_in      = res_x_ff;
         rsp_y_in      = res_y_ff;
         rsp_last_in   = res_last_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cppg_pkg::ST_IDLE;
         phase_ff     <= cppg_pkg::PH_RADIUS;
         active_ff    <= 1'b0;
         octant_ff    <= '0;
         step_ff      <= '0;
         points_ff    <= '0;
         rsq_ff       <= '0;
         ctr_x_ff     <= '0;
         ctr_y_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         active_ff    <= active_in;
         octant_ff    <= octant_in;
         step_ff      <= step_in;
         points_ff    <= points_in;
         rsq_ff       <= rsq_in;
         ctr_x_ff     <= ctr_x_in;
         ctr_y_ff     <= ctr_y_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      idx_ff        <= idx_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      rnd_ff        <= rnd_in;
      rad_ff        <= rad_in;
      root_ff       <= root_in;
      rem_ff        <= rem_in;
      res_status_ff <= res_status_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_last_ff   <= res_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int COORD_BITS  = 16;
   localparam int OUT_BITS    = COORD_BITS + 2;
   localparam int RANDOM_BEATS = 1650;
   // Hang limit: ample margin over the slowest legal run of ~1700 beats, each at worst a
   // start plus sender gaps and receiver stalls.
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic                         mode;
      logic signed [COORD_BITS-1:0] center_x;
      logic signed [COORD_BITS-1:0] center_y;
      logic signed [COORD_BITS-1:0] edge_x;
      logic signed [COORD_BITS-1:0] edge_y;
   } circle_beat_type;

   typedef struct {
      cppg_pkg::status_type       status;
      logic signed [OUT_BITS-1:0] point_x;
      logic signed [OUT_BITS-1:0] point_y;
      logic                       last_point;
   } circle_response_type;

   logic clock = 1'b0;
   logic reset;

   cppg_req_if #(.COORD_BITS(COORD_BITS)) req_if ();
   cppg_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_if ();

   circle_perimeter_point_generator_unit #(.COORD_BITS(COORD_BITS)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Beats waiting to be driven, and responses owed by the block, oldest first
   circle_beat_type     queued_requests[$];
   circle_response_type pending_responses[$];

   int queued_count   = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   // Shadow of the circle walker; all zero out of reset
   logic                         circ_active = 1'b0;
   longint                       circ_ctr_x  = 0;
   longint                       circ_ctr_y  = 0;
   longint                       circ_rsq    = 0;
   longint                       circ_count  = 0;
   logic [2:0]                   circ_octant = 3'd0;
   longint                       circ_step   = 0;

   // Integer square root, one result bit at a time from the top
   function automatic longint floor_root(longint v);
      longint r;
      longint t;
      r = 0;
      for (int k = COORD_BITS + 1; k >= 0; k--) begin
         t = r | (longint'(1) << k);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // Round half up: bump when v lies past s*s + s
   function automatic longint round_root(longint v);
      longint s;
      s = floor_root(v);
      if (v - s * s > s) s++;
      return s;
   endfunction

   // Work out the response to one accepted beat and advance the shadow state
   function automatic circle_response_type circle_response(circle_beat_type b);
      circle_response_type res;
      longint dx, dy, rad, idx, a, ox, oy;
      res.status     = cppg_pkg::STATUS_POINT;
      res.point_x    = '0;
      res.point_y    = '0;
      res.last_point = 1'b0;
      if (b.mode == cppg_pkg::MODE_START) begin
         dx = longint'(b.center_x) - longint'(b.edge_x);
         dy = longint'(b.center_y) - longint'(b.edge_y);
         rad = round_root(dx * dx + dy * dy);
         circ_active = 1'b0;
         circ_octant = 3'd0;
         circ_step   = 0;
         if (rad == 0) begin
            res.status = cppg_pkg::STATUS_TOO_SMALL;
         end else begin
            circ_ctr_x  = longint'(b.center_x);
            circ_ctr_y  = longint'(b.center_y);
            circ_rsq    = rad * rad;
            circ_count  = floor_root(circ_rsq >> 1) + 1;
            circ_active = 1'b1;
            res.status  = cppg_pkg::STATUS_STARTED;
         end
      end else if (!circ_active) begin
         res.status = cppg_pkg::STATUS_NO_CIRCLE;
      end else begin
         // odd octants walk the offsets backwards so the perimeter stays continuous
         idx = circ_octant[0] ? (circ_count - 1 - circ_step) : circ_step;
         a   = round_root(circ_rsq - idx * idx);
         case (circ_octant)
            3'd0: begin ox =  a;   oy =  idx; end
            3'd1: begin ox =  idx; oy =  a;   end
            3'd2: begin ox = -idx; oy =  a;   end
            3'd3: begin ox = -a;   oy =  idx; end
            3'd4: begin ox = -a;   oy = -idx; end
            3'd5: begin ox = -idx; oy = -a;   end
            3'd6: begin ox =  idx; oy = -a;   end
            default: begin ox = a; oy = -idx; end
         endcase
         circ_step++;
         if (circ_step >= circ_count) begin
            circ_step = 0;
            if (circ_octant == 3'd7) begin
               res.last_point = 1'b1;
               circ_active    = 1'b0;
               circ_octant    = 3'd0;
            end else begin
               circ_octant = circ_octant + 3'd1;
            end
         end
         res.point_x = OUT_BITS'(circ_ctr_x + ox);
         res.point_y = OUT_BITS'(circ_ctr_y + oy);
      end
      return res;
   endfunction

   task automatic queue_start(int cx, int cy, int ex, int ey);
      circle_beat_type b;
      b.mode     = cppg_pkg::MODE_START;
      b.center_x = COORD_BITS'(cx);
      b.center_y = COORD_BITS'(cy);
      b.edge_x   = COORD_BITS'(ex);
      b.edge_y   = COORD_BITS'(ey);
      queued_requests.push_back(b);
      queued_count++;
   endtask

   // Next beats carry random coordinates the block must ignore
   task automatic queue_next(int n);
      circle_beat_type b;
      repeat (n) begin
         b.mode     = cppg_pkg::MODE_NEXT;
         b.center_x = COORD_BITS'($urandom);
         b.center_y = COORD_BITS'($urandom);
         b.edge_x   = COORD_BITS'($urandom);
         b.edge_y   = COORD_BITS'($urandom);
         queued_requests.push_back(b);
         queued_count++;
      end
   endtask

   // Coordinates lean on the two extremes so the outputs spill past COORD_BITS
   function automatic int pick_coord();
      case ($urandom_range(0, 5))
         0: return -(1 << (COORD_BITS - 1));
         1: return (1 << (COORD_BITS - 1)) - 1;
         default: return int'($signed(COORD_BITS'($urandom)));
      endcase
   endfunction

   // Place a point near the center, flipping the offset when it would fall off the range
   function automatic int near_coord(int c, int off);
      int v;
      v = c + off;
      if (v > (1 << (COORD_BITS - 1)) - 1 || v < -(1 << (COORD_BITS - 1))) v = c - off;
      return v;
   endfunction

   // ---------------------------------------------------------------------------------
   // Driver: sends bursts of random length with random gaps in between. An
   // expectation is recorded the moment a beat is accepted, so the store of owed
   // responses always tracks exactly what the block has taken in.
   // ---------------------------------------------------------------------------------
   int              burst_left = 0;
   int              gap_left   = 0;
   circle_beat_type held_beat;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         // record the beat that just went across
         if (req_if.valid && req_if.ready) begin
            pending_responses.push_back(circle_response(held_beat));
         end
         // advance only when the channel is free; otherwise hold the beat steady
         if (!req_if.valid || req_if.ready) begin
            if (burst_left == 0 && gap_left == 0) begin
               burst_left = $urandom_range(1, 16);
               // about a third of the bursts run back to back with no gap
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (queued_requests.size() > 0) begin
               held_beat = queued_requests.pop_front();
               burst_left--;
               req_if.valid    <= 1'b1;
               req_if.mode     <= held_beat.mode;
               req_if.center_x <= held_beat.center_x;
               req_if.center_y <= held_beat.center_y;
               req_if.edge_x   <= held_beat.edge_x;
               req_if.edge_y   <= held_beat.edge_y;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Monitor: checks each response beat against the oldest owed response and
   // drives ready from a pattern that rotates through: always ready, random
   // stalls, a short periodic stall, and a long periodic stall.
   // ---------------------------------------------------------------------------------
   int                  stall_cycle = 0;
   circle_response_type owed;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: status %0d x %0d y %0d last %0d",
                           rsp_if.status, rsp_if.point_x, rsp_if.point_y,
                           rsp_if.last_point);
            end else begin
               owed = pending_responses.pop_front();
               if (rsp_if.status !== owed.status || rsp_if.point_x !== owed.point_x ||
                   rsp_if.point_y !== owed.point_y ||
                   rsp_if.last_point !== owed.last_point) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch: expected status %0d x %0d y %0d last %0d, ",
                               "got status %0d x %0d y %0d last %0d"},
                              owed.status, owed.point_x, owed.point_y, owed.last_point,
                              rsp_if.status, rsp_if.point_x, rsp_if.point_y,
                              rsp_if.last_point);
               end
            end
         end
         stall_cycle++;
         case ((stall_cycle / 400) % 4)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 9) < 7);
            2: rsp_if.ready <= ((stall_cycle % 7) < 4);
            default: rsp_if.ready <= ((stall_cycle % 50) >= 20);
         endcase
      end
   end

   // Guard against a hung block
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------
   initial begin
      int  kind, cx, cy, ex, ey, span, ddx, ddy, perim, tail;
      longint rad;

      // known values on every input before the first edge
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.mode     = cppg_pkg::MODE_START;
      req_if.center_x = '0;
      req_if.center_y = '0;
      req_if.edge_x   = '0;
      req_if.edge_y   = '0;
      rsp_if.ready    = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // next with no circle running
      queue_next(1);
      // edge on the center: too small, and the block stays idle
      queue_start(-32768, 32767, -32768, 32767);
      queue_next(1);
      // unit circle at the top corner; points land beyond the input range
      queue_start(32767, 32767, 32766, 32767);
      queue_next(8);
      // one more past the flagged last point
      queue_next(1);
      // largest radius the inputs allow, opposite corners
      queue_start(-32768, -32768, 32767, 32767);
      queue_next(3);
      // abandon it with a new start
      queue_start(0, 0, -32768, -32768);
      queue_next(1);
      // unit circle at the bottom corner, cut short by the random part
      queue_start(-32768, -32768, -32768, -32767);
      queue_next(2);

      // hold off until every owed response is back; sample between edges
      while (queued_requests.size() != 0 || req_if.valid || pending_responses.size() != 0)
         @(negedge clock);

      queued_count = 0;
      while (queued_count < RANDOM_BEATS) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            // circles with small radii and random centers, usually walked whole
            cx   = pick_coord();
            cy   = pick_coord();
            span = ($urandom_range(0, 7) == 0) ? 20 : 6;
            ddx  = $urandom_range(0, 2 * span) - span;
            ddy  = $urandom_range(0, 2 * span) - span;
            ex   = near_coord(cx, ddx);
            ey   = near_coord(cy, ddy);
            rad  = round_root(longint'(ddx) * ddx + longint'(ddy) * ddy);
            perim = (rad == 0) ? 0 : 8 * int'(floor_root((rad * rad) >> 1) + 1);
            queue_start(cx, cy, ex, ey);
            tail = $urandom_range(0, 5);
            if (tail == 0 && perim > 0) queue_next($urandom_range(1, perim));
            else if (tail == 1) queue_next(perim + 1);
            else queue_next(perim);
         end else if (kind == 7) begin
            cx = pick_coord();
            cy = pick_coord();
            queue_start(cx, cy, cx, cy);
            queue_next($urandom_range(0, 2));
         end else if (kind == 8) begin
            // large radius from fully random coordinates, abandoned early
            queue_start(pick_coord(), pick_coord(), pick_coord(), pick_coord());
            queue_next($urandom_range(1, 4));
         end else begin
            queue_next($urandom_range(1, 3));
         end
      end

      // drain, then give the block time to show anything spurious
      while (queued_requests.size() != 0 || req_if.valid || pending_responses.size() != 0)
         @(negedge clock);
      repeat (2 * COORD_BITS + 20) @(posedge clock);

      if (mismatch_count == 0 && pending_responses.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
